// ----- sv/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Command and status codes, queue flags and the state encodings.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;

  localparam int WIDTH_DEF   = 32;
  localparam int FIELD_W     = 32;
  localparam int DEN_W       = 31;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDIV = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef struct packed {
    logic err;
    logic neg;
  } flags_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_GCD,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ----- sv/rational_arithmetic_unit_core.sv -----
// Flow: the front forms three products, stopping early on a flagged operand,
//   and pushes to the queue; the back pops, runs the binary GCD loop and the
//   dividers, then strobes; errors and zero results go straight to the strobe.
// Throughput: one transaction per back pass; the GCD loop and the dividers
//   bound it. The front takes the next transaction while the back reduces,
//   two can wait.
// Reset: synchronous, active low rst_n; clears front, queue and back control.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: signed fraction add, sub, mul, div
// Front forms cross products, a two-entry queue decouples it from the back,
// which reduces by the GCD and range checks the result.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_core #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_command,
  input  wire logic [rau_pkg::FIELD_W-1:0] in_a_num,
  input  wire logic [rau_pkg::FIELD_W-1:0] in_a_den,
  input  wire logic [rau_pkg::FIELD_W-1:0] in_b_num,
  input  wire logic [rau_pkg::FIELD_W-1:0] in_b_den,
  output logic                             out_valid,
  output logic [rau_pkg::FIELD_W-1:0]      out_res_num,
  output logic [rau_pkg::DEN_W-1:0]        out_res_den,
  output logic [1:0]                       out_status
);

  localparam int PW = 2 * WIDTH;
  localparam int DW = $bits(rau_pkg::flags_t) + 2 * PW;

  // front to queue
  logic            push_valid, push_ready;
  rau_pkg::flags_t push_flags;
  logic [PW-1:0]   push_mn, push_md;

  // queue to back
  logic            pop_valid, pop_ready;
  logic [DW-1:0]   pop_data;
  rau_pkg::flags_t pop_flags;
  logic [PW-1:0]   pop_mn, pop_md;

  rau_front #(.WIDTH(WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_flags (push_flags),
    .push_mn    (push_mn),
    .push_md    (push_md)
  );

  // hold the classified transaction until the back is free
  rau_queue #(.DW(DW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_flags, push_mn, push_md}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  assign pop_flags = rau_pkg::flags_t'(pop_data[DW-1 -: $bits(rau_pkg::flags_t)]);
  assign pop_mn    = pop_data[2*PW-1:PW];
  assign pop_md    = pop_data[PW-1:0];

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_flags   (pop_flags),
    .pop_mn      (pop_mn),
    .pop_md      (pop_md),
    .out_valid   (out_valid),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

`ifndef SYNTH
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res_den != '0))
    else $error("result denominator is zero");

  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != rau_pkg::ST_OK)) |->
      ((out_res_num == '0) && (out_res_den == rau_pkg::DEN_W'(1))))
    else $error("flagged result is not 0/1");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("front did not go busy after accept");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule
`default_nettype wire

// ----- sv/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front: operand capture and cross products
// Splits operands into sign and magnitude, flags zero denominators and zero
// divisors, forms products on one shared multiplier, queues the signed pair.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_front #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_command,
  input  wire logic [rau_pkg::FIELD_W-1:0] in_a_num,
  input  wire logic [rau_pkg::FIELD_W-1:0] in_a_den,
  input  wire logic [rau_pkg::FIELD_W-1:0] in_b_num,
  input  wire logic [rau_pkg::FIELD_W-1:0] in_b_den,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output rau_pkg::flags_t                  push_flags,
  output logic [2*WIDTH-1:0]               push_mn,
  output logic [2*WIDTH-1:0]               push_md
);

  localparam int PW = 2 * WIDTH;

  function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
    mag_of = v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  rau_pkg::front_state_t state_r, state_nxt;
  rau_pkg::cmd_t         cmd_r;
  logic                  err_r;
  logic                  san_r, sad_r, sbn_r, sbd_r;
  logic [WIDTH-1:0]      man_r, mad_r, mbn_r, mbd_r;
  logic [1:0]            step_r;
  logic [PW-1:0]         p0_r, p1_r, p2_r;
  logic [WIDTH-1:0]      mul_a, mul_b;
  logic [PW-1:0]         prod;
  logic                  accept;
  logic                  sb, sx, sy, sn, sd;
  logic [PW-1:0]         mn;

  assign accept = start && (state_r == rau_pkg::F_IDLE);
  assign busy   = (state_r != rau_pkg::F_IDLE);

  always_comb begin
    mul_a = man_r;
    mul_b = mbd_r;
    unique case (step_r)
      2'd0: begin
        mul_a = man_r;
        mul_b = (cmd_r == rau_pkg::CMD_MUL) ? mbn_r : mbd_r;
      end
      2'd1: begin
        mul_a = mad_r;
        mul_b = mbn_r;
      end
      default: begin
        mul_a = mad_r;
        mul_b = (cmd_r == rau_pkg::CMD_DIV) ? mbn_r : mbd_r;
      end
    endcase
  end

  assign prod = {{WIDTH{1'b0}}, mul_a} * {{WIDTH{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::F_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        step_r <= 2'd0;
      end else if (state_r == rau_pkg::F_MUL) begin
        step_r <= step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= rau_pkg::cmd_t'(in_command);
      san_r <= in_a_num[WIDTH-1];
      sad_r <= in_a_den[WIDTH-1];
      sbn_r <= in_b_num[WIDTH-1];
      sbd_r <= in_b_den[WIDTH-1];
      man_r <= mag_of(in_a_num[WIDTH-1:0]);
      mad_r <= mag_of(in_a_den[WIDTH-1:0]);
      mbn_r <= mag_of(in_b_num[WIDTH-1:0]);
      mbd_r <= mag_of(in_b_den[WIDTH-1:0]);
      err_r <= (in_a_den[WIDTH-1:0] == '0) || (in_b_den[WIDTH-1:0] == '0) ||
               ((rau_pkg::cmd_t'(in_command) == rau_pkg::CMD_DIV) &&
                (in_b_num[WIDTH-1:0] == '0));
    end
    if (state_r == rau_pkg::F_MUL) begin
      unique case (step_r)
        2'd0:    p0_r <= prod;
        2'd1:    p1_r <= prod;
        default: p2_r <= prod;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::F_IDLE: begin
        if (start) begin
          state_nxt = rau_pkg::F_MUL;
        end
      end
      rau_pkg::F_MUL: begin
        // skip straight to the queue on a flagged operand
        if (err_r || (step_r == 2'd2)) begin
          state_nxt = rau_pkg::F_PUSH;
        end
      end
      rau_pkg::F_PUSH: begin
        if (push_ready) begin
          state_nxt = rau_pkg::F_IDLE;
        end
      end
      default: state_nxt = rau_pkg::F_IDLE;
    endcase
  end

  // signed combine of the cross products
  always_comb begin
    sb = (cmd_r == rau_pkg::CMD_SUB) ? ~sbn_r : sbn_r;
    sx = san_r ^ sbd_r;
    sy = sad_r ^ sb;
    sn = sx;
    sd = sad_r ^ sbd_r;
    mn = p0_r;
    unique case (cmd_r)
      rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
        if (sx == sy) begin
          sn = sx;
          mn = p0_r + p1_r;
        end else if (p0_r >= p1_r) begin
          sn = sx;
          mn = p0_r - p1_r;
        end else begin
          sn = sy;
          mn = p1_r - p0_r;
        end
      end
      rau_pkg::CMD_MUL: begin
        sn = san_r ^ sbn_r;
        sd = sad_r ^ sbd_r;
      end
      default: begin
        sn = san_r ^ sbd_r;
        sd = sad_r ^ sbn_r;
      end
    endcase
  end

  assign push_valid     = (state_r == rau_pkg::F_PUSH);
  assign push_flags.err = err_r;
  assign push_flags.neg = sn ^ sd;
  assign push_mn        = mn;
  assign push_md        = p2_r;

endmodule
`default_nettype wire

// ----- sv/rau_queue.sv -----
// ----------------------------------------------------------------------------
// rau_queue: short FIFO between front and back
// Register storage, one write and one read per cycle; no write while full.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire logic [DW-1:0] wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output logic [DW-1:0]      rd_data
);

  localparam int DEPTH = rau_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back: reduction and result
// Binary GCD over the product pair, then two restoring dividers in step, then
// the range check and a one-cycle result strobe; errors and zeros skip to it.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_back #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire rau_pkg::flags_t             pop_flags,
  input  wire logic [2*WIDTH-1:0]          pop_mn,
  input  wire logic [2*WIDTH-1:0]          pop_md,
  output logic                             out_valid,
  output logic [rau_pkg::FIELD_W-1:0]      out_res_num,
  output logic [rau_pkg::DEN_W-1:0]        out_res_den,
  output logic [1:0]                       out_status
);

  localparam int PW = 2 * WIDTH;
  localparam int KW = $clog2(PW);
  localparam logic [PW-1:0] LIM = PW'((65'd1 << (WIDTH - 1)) - 65'd1);

  rau_pkg::back_state_t state_r, state_nxt;
  rau_pkg::status_t     stat_r;
  logic                 neg_r;
  logic [PW-1:0]        x_r, y_r, g_r, rn_r, rd_r, qn_r, qd_r;
  logic [KW-1:0]        k_r, cnt_r;
  logic [PW:0]          sn_sh, sd_sh;
  logic                 n_ge, d_ge, ovf;
  logic [WIDTH-1:0]     num_w;

  assign pop_ready = (state_r == rau_pkg::B_IDLE);
  assign sn_sh     = {rn_r, qn_r[PW-1]};
  assign sd_sh     = {rd_r, qd_r[PW-1]};
  assign n_ge      = (sn_sh >= {1'b0, g_r});
  assign d_ge      = (sd_sh >= {1'b0, g_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::B_IDLE: begin
        if (pop_valid) begin
          if (pop_flags.err || (pop_mn == '0)) begin
            state_nxt = rau_pkg::B_OUT;
          end else begin
            state_nxt = rau_pkg::B_GCD;
          end
        end
      end
      rau_pkg::B_GCD: begin
        if (x_r == '0) begin
          state_nxt = rau_pkg::B_DIV;
        end
      end
      rau_pkg::B_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = rau_pkg::B_OUT;
        end
      end
      default: state_nxt = rau_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      rau_pkg::B_IDLE: begin
        if (pop_valid) begin
          neg_r  <= pop_flags.neg;
          stat_r <= pop_flags.err ? rau_pkg::ST_ZDIV : rau_pkg::ST_OK;
          x_r    <= pop_mn;
          y_r    <= pop_md;
          k_r    <= '0;
          if (pop_flags.err || (pop_mn == '0)) begin
            qn_r <= '0;
            qd_r <= PW'(1);
          end else begin
            qn_r <= pop_mn;
            qd_r <= pop_md;
          end
        end
      end
      rau_pkg::B_GCD: begin
        priority if (x_r == '0) begin
          g_r   <= y_r << k_r;
          rn_r  <= '0;
          rd_r  <= '0;
          cnt_r <= KW'(PW - 1);
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
      rau_pkg::B_DIV: begin
        rn_r  <= n_ge ? PW'(sn_sh - {1'b0, g_r}) : sn_sh[PW-1:0];
        rd_r  <= d_ge ? PW'(sd_sh - {1'b0, g_r}) : sd_sh[PW-1:0];
        qn_r  <= {qn_r[PW-2:0], n_ge};
        qd_r  <= {qd_r[PW-2:0], d_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign ovf = (stat_r == rau_pkg::ST_OK) &&
               ((qd_r > LIM) || (qn_r > (LIM + PW'(neg_r))));

  always_comb begin
    num_w = neg_r ? (~qn_r[WIDTH-1:0] + 1'b1) : qn_r[WIDTH-1:0];
    out_valid   = (state_r == rau_pkg::B_OUT);
    out_status  = ovf ? rau_pkg::ST_OVF : stat_r;
    out_res_num = rau_pkg::FIELD_W'(signed'(num_w));
    out_res_den = rau_pkg::DEN_W'(qd_r[WIDTH-2:0]);
    if (ovf || (stat_r != rau_pkg::ST_OK)) begin
      out_res_num = '0;
      out_res_den = rau_pkg::DEN_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- dv/rational_arithmetic_unit_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb: self-checking bench for the fraction unit
// Drives a table of directed transactions, then random ones, predicts each
// reduced fraction and status, and compares every strobed result in order.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_core_tb;

  localparam int W          = 32;
  localparam int N_RANDOM   = 930;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    rau_pkg::cmd_t op;
    logic [31:0]   an, ad, bn, bd;
  } frac_op_t;

  typedef struct {
    logic [31:0]      num;
    logic [30:0]      den;
    rau_pkg::status_t st;
  } frac_res_t;

  typedef struct {
    frac_op_t  op;
    bit        typed;   // expected result given in the table
    frac_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic        out_valid;
  logic [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic [1:0]  out_status;

  frac_res_t pending_q[$];
  int        n_errors = 0;
  int        idle_cycles = 0;
  bit        stim_done = 1'b0;

  always #1 clk = ~clk;

  rational_arithmetic_unit_core #(.WIDTH(W)) dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .out_valid, .out_res_num, .out_res_den, .out_status
  );

  // Split a 32-bit two's complement field into sign and magnitude.
  function automatic void to_sm(input logic [31:0] v, output bit s, output logic [63:0] m);
    s = v[31];
    m = s ? 64'(33'h1_0000_0000 - {1'b0, v}) : 64'(v);
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_fraction(input frac_op_t o);
    frac_res_t   r;
    bit          san, sad, sbn, sbd, sn, sd, sx, sy;
    logic [63:0] man, mad, mbn, mbd, mn, md, mx, my, g;
    logic [63:0] lim;
    lim = 64'h7FFF_FFFF;
    r.num = '0;
    r.den = 31'd1;
    to_sm(o.an, san, man);
    to_sm(o.ad, sad, mad);
    to_sm(o.bn, sbn, mbn);
    to_sm(o.bd, sbd, mbd);
    if (mad == 0 || mbd == 0 || (o.op == rau_pkg::CMD_DIV && mbn == 0)) begin
      r.st = rau_pkg::ST_ZDIV;
      return r;
    end
    case (o.op)
      rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
        sx = san != sbd;
        mx = man * mbd;
        sy = sad != ((o.op == rau_pkg::CMD_SUB) ? !sbn : sbn);
        my = mad * mbn;
        if (sx == sy) begin
          sn = sx; mn = mx + my;
        end else if (mx >= my) begin
          sn = sx; mn = mx - my;
        end else begin
          sn = sy; mn = my - mx;
        end
        sd = sad != sbd;
        md = mad * mbd;
      end
      rau_pkg::CMD_MUL: begin
        sn = san != sbn; mn = man * mbn;
        sd = sad != sbd; md = mad * mbd;
      end
      default: begin
        sn = san != sbd; mn = man * mbd;
        sd = sad != sbn; md = mad * mbn;
      end
    endcase
    r.st = rau_pkg::ST_OK;
    if (mn == 0) return r;
    g = gcd64(mn, md);
    mn = mn / g;
    md = md / g;
    sn = sn != sd;
    if (md > lim || mn > lim + (sn ? 64'd1 : 64'd0)) begin
      r.st = rau_pkg::ST_OVF;
      return r;
    end
    r.num = sn ? 32'(64'd0 - mn) : mn[31:0];
    r.den = md[30:0];
    return r;
  endfunction

  // Check every strobed result at the rising edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result %0d/%0d status %0d", $signed(out_res_num),
               out_res_den, out_status);
        n_errors++;
      end else begin
        frac_res_t e;
        e = pending_q.pop_front();
        if (out_res_num !== e.num) begin
          $error("res_num exp %0d got %0d", $signed(e.num), $signed(out_res_num));
          n_errors++;
        end
        if (out_res_den !== e.den) begin
          $error("res_den exp %0d got %0d", e.den, out_res_den);
          n_errors++;
        end
        if (out_status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_status);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("rational_arithmetic_unit_core_tb: done, errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Drive one transaction on the falling edge; hold until accepted.
  // Start stays high on return; the caller drops it before any gap.
  // The typed expectation, when given, replaces the predicted one.
  task automatic send_op(input frac_op_t o, input bit typed, input frac_res_t tr);
    frac_res_t p;
    p = reduce_fraction(o);
    if (typed && (p.num !== tr.num || p.den !== tr.den || p.st !== tr.st)) begin
      $error("table row disagrees with prediction for cmd %0d", o.op);
      n_errors++;
    end
    in_command <= o.op;
    in_a_num   <= o.an;
    in_a_den   <= o.ad;
    in_b_num   <= o.bn;
    in_b_den   <= o.bd;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    pending_q.push_back(typed ? tr : p);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_field(input bit nonzero);
    logic [31:0] v;
    int          k;
    k = $urandom_range(0, 9);
    case (k)
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'hFFFF_FFFF;
      3, 4:    v = $urandom();
      default: v = 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
    if (nonzero && v == 0) v = 32'd7;
    return v;
  endfunction

  frac_res_t zdiv_r, ovf_r, zero_r;
  dir_row_t  dir_tab[$];

  function automatic dir_row_t mk(rau_pkg::cmd_t c, int an, int ad, int bn, int bd,
                                  bit typed, frac_res_t r);
    dir_row_t d;
    d.op = '{c, an, ad, bn, bd};
    d.typed = typed;
    d.res = r;
    return d;
  endfunction

  initial begin
    frac_op_t  o;
    frac_res_t none;
    int        gap;
    none   = '{32'd0, 31'd1, rau_pkg::ST_OK};
    zdiv_r = '{32'd0, 31'd1, rau_pkg::ST_ZDIV};
    ovf_r  = '{32'd0, 31'd1, rau_pkg::ST_OVF};
    zero_r = none;

    // Directed table: error codes, zero results, extremes, each command.
    dir_tab.push_back(mk(rau_pkg::CMD_ADD, 1, 0, 1, 1, 1, zdiv_r));
    dir_tab.push_back(mk(rau_pkg::CMD_MUL, 1, 1, 1, 0, 1, zdiv_r));
    dir_tab.push_back(mk(rau_pkg::CMD_DIV, 3, 4, 0, 5, 1, zdiv_r));
    dir_tab.push_back(mk(rau_pkg::CMD_DIV, 0, 0, 0, 0, 1, zdiv_r));
    dir_tab.push_back(mk(rau_pkg::CMD_SUB, 5, 7, 5, 7, 1, zero_r));
    dir_tab.push_back(mk(rau_pkg::CMD_MUL, 0, 9, -3, 4, 1, zero_r));
    dir_tab.push_back(mk(rau_pkg::CMD_ADD, 1, 2, 1, 2, 1,
                         '{32'd1, 31'd1, rau_pkg::ST_OK}));
    dir_tab.push_back(mk(rau_pkg::CMD_ADD, 4, 2, 0, 1, 1,
                         '{32'd2, 31'd1, rau_pkg::ST_OK}));
    dir_tab.push_back(mk(rau_pkg::CMD_MUL, 1, -2, 1, 3, 1,
                         '{-32'sd1, 31'd6, rau_pkg::ST_OK}));
    dir_tab.push_back(mk(rau_pkg::CMD_DIV, 1, 3, -1, 3, 1,
                         '{-32'sd1, 31'd1, rau_pkg::ST_OK}));
    dir_tab.push_back(mk(rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 1, 2, 1, 1, ovf_r));
    dir_tab.push_back(mk(rau_pkg::CMD_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE, 1,
                         ovf_r));
    dir_tab.push_back(mk(rau_pkg::CMD_MUL, 32'h8000_0000, 1, 1, 1, 1,
                         '{32'h8000_0000, 31'd1, rau_pkg::ST_OK}));
    dir_tab.push_back(mk(rau_pkg::CMD_MUL, 32'h8000_0000, 1, -1, 1, 1, ovf_r));
    dir_tab.push_back(mk(rau_pkg::CMD_DIV, 1, 32'h8000_0000, 1, 1, 1, ovf_r));
    dir_tab.push_back(mk(rau_pkg::CMD_MUL, 1, -1, 1, 32'h8000_0000, 1, ovf_r));
    dir_tab.push_back(mk(rau_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0000, -1, 3, 0,
                         none));
    dir_tab.push_back(mk(rau_pkg::CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 0, none));
    dir_tab.push_back(mk(rau_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 0, none));
    dir_tab.push_back(mk(rau_pkg::CMD_SUB, 1234, -5678, -91011, 121314, 0, none));
    dir_tab.push_back(mk(rau_pkg::CMD_DIV, 6, -4, 9, -2, 0, none));

    // Hold reset low, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].res);

    // Drain fully before the random part: the sender pauses here.
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      o.op = rau_pkg::cmd_t'($urandom_range(0, 3));
      o.an = rand_field(1'b0);
      o.ad = ($urandom_range(0, 49) == 0) ? 32'd0 : rand_field(1'b1);
      o.bn = rand_field(1'b0);
      o.bd = ($urandom_range(0, 49) == 0) ? 32'd0 : rand_field(1'b1);
      // Runs of back-to-back transactions alternate with random gaps.
      gap = ((n / 64) % 3 == 1) ? 0 : pick_gap();
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      send_op(o, 1'b0, none);
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
      end
    end

    stim_done = 1'b1;
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (n_errors == 0 && pending_q.size() == 0)
      $display("rational_arithmetic_unit_core_tb: done, clean");
    else
      $display("rational_arithmetic_unit_core_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
